[src/vrg_pkg.sv]
// Shared types and constants of the VGA attribute raster generator.
package vrg_pkg;

  // Raster timing, in output bytes and lines
  localparam int LINE_BYTES       = 400;
  localparam int HSYNC_BYTES      = 48;
  localparam int BACK_PORCH_BYTES = 24;
  localparam int FRAME_LINES      = 525;
  localparam int VSYNC_START_LINE = 490;
  localparam int VSYNC_LINES      = 2;
  localparam int SOURCE_LINES     = 240;

  // Picture geometry
  localparam int VISIBLE_BYTES  = 320;
  localparam int VIS_START      = HSYNC_BYTES + BACK_PORCH_BYTES;
  localparam int VIS_END        = VIS_START + VISIBLE_BYTES;
  localparam int VIS_LINES      = 2 * SOURCE_LINES;
  localparam int WORD_W         = 32;
  localparam int WORDS_PER_LINE = VISIBLE_BYTES / WORD_W;
  localparam int CELL_PIX       = 8;
  localparam int CELLS_PER_ROW  = VISIBLE_BYTES / CELL_PIX;
  localparam int CELL_ROWS      = SOURCE_LINES / CELL_PIX;
  localparam int PIXEL_DEPTH    = SOURCE_LINES * WORDS_PER_LINE;
  localparam int ATTR_DEPTH     = CELL_ROWS * CELLS_PER_ROW;

  // Counter and address widths
  localparam int COL_W     = $clog2(LINE_BYTES);
  localparam int LINE_W    = $clog2(FRAME_LINES);
  localparam int SRC_W     = $clog2(SOURCE_LINES);
  localparam int P_W       = $clog2(VISIBLE_BYTES);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int PIX_AW    = $clog2(PIXEL_DEPTH);
  localparam int ATTR_AW   = $clog2(ATTR_DEPTH);
  localparam int CELL_SH   = $clog2(CELL_PIX);

  // Transaction fields
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 32;
  localparam int COLOUR_W   = 6;
  localparam int BYTE_W     = 8;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 8;

  // Item kinds carried in the slave tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 2'd0,
    MODE_PIXEL_WR = 2'd1,
    MODE_FG_WR    = 2'd2,
    MODE_BG_WR    = 2'd3
  } mode_e;

endpackage

[src/vrg_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module vrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/vga_attribute_raster_generator.sv]
// VGA raster generator: 1 bit per pixel with 8x8 foreground/background attribute cells.
//
// Every pixel-tick transaction (tuser 0) yields one video byte {vsync_n, hsync_n,
// colour[5:0]} for the current raster position and advances it; the column wraps at
// 400 and the line at 525. Write transactions (tuser 1, 2, 3) fill the pixel word,
// foreground and background stores, give no output and leave the position alone;
// out-of-range addresses are dropped. The block takes one transaction per clock and
// sustains one video byte per cycle for back-to-back ticks while the master side accepts.
// After acceptance the three stores are read through a registered read, then pixel and
// colour are selected into the output register. A stall on the master side holds the
// whole pipe. The stores are not cleared by reset; fill them before the first visible frame.
module vga_attribute_raster_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [11:0] address, [43:12] write_data, [47:44] zero
  input  logic [vrg_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [vrg_pkg::MODE_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] video_byte
  output logic [vrg_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  // Pipeline control
  logic advance;
  logic accept;
  logic is_tick;

  // Raster position
  logic [vrg_pkg::COL_W-1:0]  col_q, col_d;
  logic [vrg_pkg::LINE_W-1:0] line_q, line_d;

  // Decode of the current position
  logic                        hs_n;
  logic                        vs_n;
  logic                        visible;
  logic [vrg_pkg::P_W-1:0]     p;
  logic [vrg_pkg::SRC_W-1:0]   src;
  logic [vrg_pkg::PIX_AW-1:0]  pix_raddr;
  logic [vrg_pkg::ATTR_AW-1:0] attr_raddr;

  // Write side
  logic [vrg_pkg::ADDR_W-1:0]   in_addr;
  logic [vrg_pkg::DATA_W-1:0]   in_data;
  vrg_pkg::mode_e               in_mode;
  logic                         pix_we;
  logic                         fg_we;
  logic                         bg_we;

  // Store read data
  logic [vrg_pkg::WORD_W-1:0]   pix_rdata;
  logic [vrg_pkg::COLOUR_W-1:0] fg_rdata;
  logic [vrg_pkg::COLOUR_W-1:0] bg_rdata;

  // Stage 1: read in flight
  logic                       s1_valid_q;
  logic                       s1_hs_n_q;
  logic                       s1_vs_n_q;
  logic                       s1_vis_q;
  logic [vrg_pkg::BIT_W-1:0]  s1_bit_q;

  // Stage 2: output register
  logic                         out_valid_q;
  logic [vrg_pkg::BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                         pix_bit;
  logic [vrg_pkg::COLOUR_W-1:0] colour;

  // Move the pipe whenever the output slot is free or being drained
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign accept          = s_axis_tvalid_i && advance;

  // Unpack the transaction
  assign in_mode = vrg_pkg::mode_e'(s_axis_tuser_i);
  assign in_addr = s_axis_tdata_i[vrg_pkg::ADDR_W-1:0];
  assign in_data = s_axis_tdata_i[vrg_pkg::ADDR_W +: vrg_pkg::DATA_W];
  assign is_tick = (in_mode == vrg_pkg::MODE_TICK);

  // Decode sync and visible window from the raster position
  always_comb begin
    hs_n    = !(col_q < vrg_pkg::COL_W'(vrg_pkg::HSYNC_BYTES));
    vs_n    = !((line_q >= vrg_pkg::LINE_W'(vrg_pkg::VSYNC_START_LINE)) &&
                (line_q < vrg_pkg::LINE_W'(vrg_pkg::VSYNC_START_LINE +
                                            vrg_pkg::VSYNC_LINES)));
    visible = (line_q < vrg_pkg::LINE_W'(vrg_pkg::VIS_LINES)) &&
              (col_q >= vrg_pkg::COL_W'(vrg_pkg::VIS_START)) &&
              (col_q < vrg_pkg::COL_W'(vrg_pkg::VIS_END));
    p       = vrg_pkg::P_W'(col_q - vrg_pkg::COL_W'(vrg_pkg::VIS_START));
    src     = vrg_pkg::SRC_W'(line_q >> 1);
  end

  // Store addresses for the pixel word and the attribute cell
  always_comb begin
    pix_raddr  = vrg_pkg::PIX_AW'(src * vrg_pkg::WORDS_PER_LINE +
                                  (p >> vrg_pkg::BIT_W));
    attr_raddr = vrg_pkg::ATTR_AW'((src >> vrg_pkg::CELL_SH) * vrg_pkg::CELLS_PER_ROW +
                                   (p >> vrg_pkg::CELL_SH));
  end

  // Store writes, dropped when out of range
  always_comb begin
    pix_we = accept && (in_mode == vrg_pkg::MODE_PIXEL_WR) &&
             (in_addr < vrg_pkg::ADDR_W'(vrg_pkg::PIXEL_DEPTH));
    fg_we  = accept && (in_mode == vrg_pkg::MODE_FG_WR) &&
             (in_addr < vrg_pkg::ADDR_W'(vrg_pkg::ATTR_DEPTH));
    bg_we  = accept && (in_mode == vrg_pkg::MODE_BG_WR) &&
             (in_addr < vrg_pkg::ADDR_W'(vrg_pkg::ATTR_DEPTH));
  end

  vrg_ram #(
    .WIDTH (vrg_pkg::WORD_W),
    .DEPTH (vrg_pkg::PIXEL_DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (in_addr[vrg_pkg::PIX_AW-1:0]),
    .wdata_i (in_data),
    .re_i    (advance),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  vrg_ram #(
    .WIDTH (vrg_pkg::COLOUR_W),
    .DEPTH (vrg_pkg::ATTR_DEPTH)
  ) u_fg_ram (
    .clk_i   (clk_i),
    .we_i    (fg_we),
    .waddr_i (in_addr[vrg_pkg::ATTR_AW-1:0]),
    .wdata_i (in_data[vrg_pkg::COLOUR_W-1:0]),
    .re_i    (advance),
    .raddr_i (attr_raddr),
    .rdata_o (fg_rdata)
  );

  vrg_ram #(
    .WIDTH (vrg_pkg::COLOUR_W),
    .DEPTH (vrg_pkg::ATTR_DEPTH)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (bg_we),
    .waddr_i (in_addr[vrg_pkg::ATTR_AW-1:0]),
    .wdata_i (in_data[vrg_pkg::COLOUR_W-1:0]),
    .re_i    (advance),
    .raddr_i (attr_raddr),
    .rdata_o (bg_rdata)
  );

  // Advance the raster position on each pixel tick
  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (accept && is_tick) begin
      if (col_q == vrg_pkg::COL_W'(vrg_pkg::LINE_BYTES - 1)) begin
        col_d = '0;
        if (line_q == vrg_pkg::LINE_W'(vrg_pkg::FRAME_LINES - 1)) begin
          line_d = '0;
        end else begin
          line_d = line_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  // Stage 1: hold timing bits alongside the store reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept && is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hs_n_q <= hs_n;
      s1_vs_n_q <= vs_n;
      s1_vis_q  <= visible;
      s1_bit_q  <= p[vrg_pkg::BIT_W-1:0];
    end
  end

  // Stage 2: pick the pixel bit, MSB first, and its cell colour
  always_comb begin
    pix_bit    = pix_rdata[vrg_pkg::BIT_W'(vrg_pkg::WORD_W - 1) - s1_bit_q];
    colour     = pix_bit ? fg_rdata : bg_rdata;
    out_byte_d = {s1_vs_n_q, s1_hs_n_q,
                  s1_vis_q ? colour : vrg_pkg::COLOUR_W'(0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;

endmodule

[dv/testbench.sv]
// Self-checking stream testbench for the VGA attribute raster generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vrg_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1600;
  // source lines and attribute rows filled up front; the run never draws past them
  localparam int FILL_WORDS   = CELL_PIX * WORDS_PER_LINE;
  localparam int FILL_CELLS   = CELLS_PER_ROW;
  localparam int IDLE_PCT     = 17;
  localparam int QUIET_FROM   = 800;
  localparam int QUIET_TO     = 1400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int VSYNC_N_BIT  = 7;
  localparam int HSYNC_N_BIT  = 6;
  localparam int ADDR_SPAN    = 1 << ADDR_W;

  typedef struct {
    mode_e               kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
  } bus_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Slave side, driven by the testbench
  logic                  s_valid = 1'b0;
  mode_e                 s_kind  = MODE_TICK;
  logic [ADDR_W-1:0]     s_addr  = '0;
  logic [DATA_W-1:0]     s_wdata = '0;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_tdata;

  // Master side
  logic                  m_ready = 1'b0;
  logic                  m_axis_tvalid_o;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;

  // Pending transactions and the video bytes they must produce
  bus_item_t             stim_q[$];
  bus_item_t             cur_item;
  logic [BYTE_W-1:0]     video_q[$];

  // Shadow copy of the raster position and the three stores
  logic [COL_W-1:0]      col_q  = '0;
  logic [LINE_W-1:0]     line_q = '0;
  logic [DATA_W-1:0]     pix_mem [PIXEL_DEPTH];
  logic [COLOUR_W-1:0]   fg_mem  [ATTR_DEPTH];
  logic [COLOUR_W-1:0]   bg_mem  [ATTR_DEPTH];

  int                    cycle_cnt   = 0;
  int                    stall_cnt   = 0;
  int                    fail_cnt    = 0;
  int                    tick_cnt    = 0;
  int                    write_cnt   = 0;
  int                    byte_cnt    = 0;
  int                    frame_wraps = 0;
  int                    gen_ticks   = 0;
  logic [BYTE_W-1:0]     want_byte;

  // [11:0] address, [43:12] write_data, [47:44] zero
  assign s_tdata = {{(S_TDATA_W - ADDR_W - DATA_W){1'b0}}, s_wdata, s_addr};

  vga_attribute_raster_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Byte for one raster position: sync from timing, colour from the stores
  function automatic logic [BYTE_W-1:0] predict_video_byte(int col, int line);
    int                  p;
    int                  src;
    int                  widx;
    int                  cidx;
    logic [DATA_W-1:0]   word;
    logic [BYTE_W-1:0]   v;
    v = '0;
    v[VSYNC_N_BIT] = 1'b1;
    v[HSYNC_N_BIT] = 1'b1;
    if (col < HSYNC_BYTES) v[HSYNC_N_BIT] = 1'b0;
    if (line >= VSYNC_START_LINE && line < VSYNC_START_LINE + VSYNC_LINES) begin
      v[VSYNC_N_BIT] = 1'b0;
    end
    if (line < VIS_LINES && col >= VIS_START && col < VIS_END) begin
      p    = col - VIS_START;
      src  = line / 2;
      widx = src * WORDS_PER_LINE + p / WORD_W;
      cidx = (src / CELL_PIX) * CELLS_PER_ROW + p / CELL_PIX;
      word = pix_mem[widx];
      v[COLOUR_W-1:0] = word[WORD_W - 1 - (p % WORD_W)] ? fg_mem[cidx] : bg_mem[cidx];
    end
    return v;
  endfunction

  // Random back-pressure and gaps, switched off inside the quiet window
  function automatic bit take_break();
    if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic void push_tick();
    stim_q.push_back('{MODE_TICK, ADDR_W'($urandom), $urandom});
    gen_ticks++;
  endfunction

  function automatic void push_write(mode_e kind, int addr, logic [DATA_W-1:0] wdata);
    stim_q.push_back('{kind, ADDR_W'(addr), wdata});
  endfunction

  // Drive the slave side and the master ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_kind  <= MODE_TICK;
      s_addr  <= '0;
      s_wdata <= '0;
      m_ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (!s_valid || s_axis_tready_o) begin
        if (stim_q.size() != 0 && !take_break()) begin
          cur_item = stim_q.pop_front();
          s_valid <= 1'b1;
          s_kind  <= cur_item.kind;
          s_addr  <= cur_item.addr;
          s_wdata <= cur_item.wdata;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= !take_break();
    end
  end

  // Check video bytes, update the shadow model on accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cnt++;
      if (m_axis_tvalid_o && m_ready) begin
        stall_cnt = 0;
        byte_cnt++;
        if (video_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: video byte with none expected: expected none, actual %02h",
                   $time, m_axis_tdata_o);
        end else begin
          want_byte = video_q.pop_front();
          if (m_axis_tdata_o !== want_byte) begin
            fail_cnt++;
            $display("%0t: video byte mismatch: expected %02h, actual %02h",
                     $time, want_byte, m_axis_tdata_o);
          end
        end
      end
      if (s_valid && s_axis_tready_o) begin
        stall_cnt = 0;
        case (s_kind)
          MODE_TICK: begin
            tick_cnt++;
            video_q.push_back(predict_video_byte(col_q, line_q));
            if (col_q == COL_W'(LINE_BYTES - 1)) begin
              col_q = '0;
              if (line_q == LINE_W'(FRAME_LINES - 1)) begin
                line_q = '0;
                frame_wraps++;
              end else begin
                line_q++;
              end
            end else begin
              col_q++;
            end
          end
          MODE_PIXEL_WR: begin
            write_cnt++;
            if (s_addr < PIXEL_DEPTH) pix_mem[s_addr] = s_wdata;
          end
          MODE_FG_WR: begin
            write_cnt++;
            if (s_addr < ATTR_DEPTH) fg_mem[s_addr] = s_wdata[COLOUR_W-1:0];
          end
          default: begin
            write_cnt++;
            if (s_addr < ATTR_DEPTH) bg_mem[s_addr] = s_wdata[COLOUR_W-1:0];
          end
        endcase
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Build the stimulus, then wait for the pipe to drain and report
  initial begin
    int     n_rand;
    int     burst;
    int     pick;
    int     gen_line;
    int     cur_src;
    int     addr;
    mode_e  kind;

    // Fill the first cell row of source lines so no visible pixel reads unwritten data
    for (int i = 0; i < FILL_WORDS; i++) push_write(MODE_PIXEL_WR, i, $urandom);
    for (int i = 0; i < FILL_CELLS; i++) push_write(MODE_FG_WR, i, $urandom);
    for (int i = 0; i < FILL_CELLS; i++) push_write(MODE_BG_WR, i, $urandom);

    // Directed: ignored tick fields, data and address extremes,
    // attribute high bits dropped, out-of-range writes dropped
    stim_q.push_back('{MODE_TICK, '1, '1});
    stim_q.push_back('{MODE_TICK, '0, '0});
    gen_ticks += 2;
    push_write(MODE_PIXEL_WR, 0, '1);
    push_write(MODE_PIXEL_WR, 1, '0);
    push_write(MODE_PIXEL_WR, PIXEL_DEPTH - 1, '1);
    push_write(MODE_FG_WR, 0, '1);
    push_write(MODE_BG_WR, 0, 32'hFFFF_FFC0);
    push_write(MODE_FG_WR, ATTR_DEPTH - 1, '0);
    push_write(MODE_BG_WR, ATTR_DEPTH - 1, '1);
    push_write(MODE_PIXEL_WR, PIXEL_DEPTH, '0);
    push_write(MODE_PIXEL_WR, ADDR_SPAN - 1, '0);
    push_write(MODE_FG_WR, ATTR_DEPTH, '0);
    push_write(MODE_BG_WR, ADDR_SPAN - 1, '0);
    repeat (8) push_tick();

    // Random mix: tick bursts and writes, part of them aimed at the line being drawn
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 55) begin
        burst = $urandom_range(1, 24);
        repeat (burst) push_tick();
        n_rand += burst;
      end else begin
        kind     = mode_e'($urandom_range(1, 3));
        gen_line = (gen_ticks / LINE_BYTES) % FRAME_LINES;
        cur_src  = (gen_line < VIS_LINES) ? gen_line / 2 : $urandom_range(SOURCE_LINES - 1);
        pick     = $urandom_range(99);
        if (pick < 12) begin
          addr = $urandom_range(ADDR_SPAN - 1);
        end else if (kind == MODE_PIXEL_WR) begin
          addr = (pick < 56) ? cur_src * WORDS_PER_LINE + $urandom_range(WORDS_PER_LINE - 1)
                             : $urandom_range(PIXEL_DEPTH - 1);
        end else begin
          addr = (pick < 56) ? (cur_src / CELL_PIX) * CELLS_PER_ROW
                               + $urandom_range(CELLS_PER_ROW - 1)
                             : $urandom_range(ATTR_DEPTH - 1);
        end
        push_write(kind, addr, $urandom);
        n_rand++;
      end
    end

    @(posedge rst_ni);
    while (stim_q.size() != 0 || s_valid || video_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixel ticks and %0d store writes, checked %0d video bytes.",
             tick_cnt, write_cnt, byte_cnt);
    $display("Raster wrapped %0d frame(s), ending on line %0d column %0d.",
             frame_wraps, line_q, col_q);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
src/vrg_pkg.sv
src/vrg_ram.sv
src/vga_attribute_raster_generator.sv
dv/testbench.sv
